[rtl/lkat_pkg.sv]
package lkat_pkg;

  localparam int DIFF_W     = 33;  // aim - eye, exact
  localparam int MAG_W      = 30;  // scaled magnitude, top one in [2^29, 2^30)
  localparam int SCALE_TOP  = 29;
  localparam int POS_W      = 6;
  localparam int RAD_W      = 62;  // sum of squares
  localparam int ROOT_W     = 31;
  localparam int REM_W      = 35;
  localparam int SQRT_STEPS = 31;
  localparam int OUT_W      = 16;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                  degen;
    logic [2:0]            fneg;
    logic [2:0][MAG_W-1:0] fmag;
    logic [1:0][MAG_W-1:0] hmag;  // [0] = x, [1] = z
  } side_t;

  // One digit of the restoring square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] b);
    sqrt_t            r;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    cur   = {s.rem[REM_W-3:0], b};
    trial = {2'b00, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] msb_pos(input logic [DIFF_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < DIFF_W; i++) begin
      if (v[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  // Bring magnitude m to the common scale whose top bit sits at SCALE_TOP.
  function automatic logic [MAG_W-1:0] scale_mag(input logic [DIFF_W-1:0] m,
                                                 input logic [POS_W-1:0]  p);
    logic [DIFF_W-1:0] s;
    if (p > POS_W'(SCALE_TOP)) begin
      s = m >> (p - POS_W'(SCALE_TOP));
    end else begin
      s = m << (POS_W'(SCALE_TOP) - p);
    end
    return s[MAG_W-1:0];
  endfunction

endpackage

[rtl/look_at_rotation_matrix.sv]
// Look-at rotation matrix.
// Input channel: eye and aim positions, signed Q16.16, handshake in_valid/in_stall.
// Output channel: nine matrix entries in signed Q2.14 (OUT_FRAC_BITS fraction
// bits, masked to 16) plus a degenerate flag, handshake out_valid/out_stall.
// A request is taken on an edge with in_valid high and in_stall low.
// The pipeline is the stages of difference, scaling and squaring, 31 square-root
// digit stages, one divider setup stage, OUT_FRAC_BITS + 1 divider bit stages
// and the stages of sign, cross product and rounding. Throughput is one request
// per cycle while the receiver does not stall.
// When the receiver stalls with a result in the output register, the whole
// pipeline holds and in_stall rises in the same cycle; nothing is lost or
// repeated. When aim - eye has zero x and z, all entries are zero and
// degenerate is set. Reset clears all valid bits; no clearing pass is needed.
module look_at_rotation_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] aim_x,
  input  logic signed [31:0] aim_y,
  input  logic signed [31:0] aim_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] m_neg_right_x,
  output logic signed [15:0] m_up_x,
  output logic signed [15:0] m_neg_fwd_x,
  output logic signed [15:0] m_right_y,
  output logic signed [15:0] m_up_y,
  output logic signed [15:0] m_neg_fwd_y,
  output logic signed [15:0] m_neg_right_z,
  output logic signed [15:0] m_up_z,
  output logic signed [15:0] m_neg_fwd_z,
  output logic               degenerate
);

  localparam int F   = OUT_FRAC_BITS;
  localparam int QB  = F + 1;          // quotient bits, quotient <= 2^F
  localparam int QW  = F + 2;          // signed unit component
  localparam int RW  = 32;             // divider remainder
  localparam int AW  = RW + QB;        // divider accumulator
  localparam int PW  = 2 * QW;
  localparam int SW  = PW + 1;
  localparam int NS  = lkat_pkg::SQRT_STEPS;
  localparam int DW  = lkat_pkg::DIFF_W;
  localparam int MW  = lkat_pkg::MAG_W;
  localparam int LW  = lkat_pkg::ROOT_W;
  localparam int OW  = lkat_pkg::OUT_W;

  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                             input logic [LW-1:0] dvs);
    logic [AW-1:0] sh;
    logic [RW-1:0] up;
    sh = {acc[AW-2:0], 1'b0};
    up = sh[AW-1:QB];
    if (up >= RW'(dvs)) begin
      up = up - RW'(dvs);
      sh[0] = 1'b1;
    end
    return {up, sh[QB-1:0]};
  endfunction

  function automatic logic [AW-1:0] div_init(input logic [MW-1:0] m,
                                             input logic [LW-1:0] dvs);
    return (AW'(m) << F) + AW'(dvs >> 1);
  endfunction

  function automatic logic signed [QW-1:0] to_unit(input logic [QB-1:0] q,
                                                   input logic neg);
    logic [QB-1:0]         c;
    logic signed [QW-1:0]  s;
    c = (q > (QB'(1) << F)) ? (QB'(1) << F) : q;
    s = QW'(c);
    return neg ? -s : s;
  endfunction

  function automatic logic [OW-1:0] neg_out(input logic signed [QW-1:0] v);
    logic signed [SW-1:0] e;
    e = -SW'(v);
    return e[OW-1:0];
  endfunction

  function automatic logic [OW-1:0] round_out(input logic signed [SW-1:0] v);
    logic [SW-1:0]        m;
    logic [SW-1:0]        q;
    logic signed [SW-1:0] r;
    m = v[SW-1] ? SW'(-v) : SW'(v);
    q = (m + (SW'(1) << (F - 1))) >> F;
    if (q > (SW'(1) << F)) begin
      q = SW'(1) << F;
    end
    r = v[SW-1] ? -$signed(q) : $signed(q);
    return r[OW-1:0];
  endfunction

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: difference
  logic signed [DW-1:0] dx, dy, dz;
  assign dx = DW'(aim_x) - DW'(eye_x);
  assign dy = DW'(aim_y) - DW'(eye_y);
  assign dz = DW'(aim_z) - DW'(eye_z);

  logic          v1;
  logic          s1_deg;
  logic [2:0]    s1_neg;
  logic [DW-1:0] s1_mag [3];

  // stage 2: leading one of both vectors
  logic                          v2;
  logic                          s2_deg;
  logic [2:0]                    s2_neg;
  logic [DW-1:0]                 s2_mag [3];
  logic [lkat_pkg::POS_W-1:0]    s2_pf, s2_ph;

  // stage 3: scaled, stage 4: squares, stage 5: sums
  logic                  v3, v4, v5;
  lkat_pkg::side_t       s3_side, s4_side, s5_side;
  logic [2*MW-1:0]       s4_fsq [3];
  logic [2*MW-1:0]       s4_hsq [2];
  logic [lkat_pkg::RAD_W-1:0] s5_fsum, s5_hsum;

  // square root digit stages
  logic                       qv    [NS];
  lkat_pkg::side_t            qside [NS];
  lkat_pkg::sqrt_t            qf    [NS];
  lkat_pkg::sqrt_t            qh    [NS];
  logic [lkat_pkg::RAD_W-1:0] qfr   [NS];
  logic [lkat_pkg::RAD_W-1:0] qhr   [NS];

  // divider stages, lanes: 0..2 forward, 3 right x, 4 right z
  logic          dv    [QB+1];
  logic          ddeg  [QB+1];
  logic [4:0]    dneg  [QB+1];
  logic [LW-1:0] dl    [QB+1];
  logic [LW-1:0] dh    [QB+1];
  logic [AW-1:0] dacc  [QB+1][5];

  // sign, products, sums
  logic                 cv, pv, sv;
  logic                 c_deg, p_deg, s_deg;
  logic signed [QW-1:0] c_val [5];
  logic signed [QW-1:0] p_val [5];
  logic signed [QW-1:0] s_val [5];
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [SW-1:0] s_e1, s_e4, s_e7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        qv[k] <= 1'b0;
      end
      for (int k = 0; k <= QB; k++) begin
        dv[k] <= 1'b0;
      end
      cv        <= 1'b0;
      pv        <= 1'b0;
      sv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      qv[0] <= v5;
      for (int k = 1; k < NS; k++) begin
        qv[k] <= qv[k-1];
      end
      dv[0] <= qv[NS-1];
      for (int k = 1; k <= QB; k++) begin
        dv[k] <= dv[k-1];
      end
      cv        <= dv[QB];
      pv        <= cv;
      sv        <= pv;
      out_valid <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_deg    <= (dx == '0) && (dz == '0);
      s1_neg    <= {dz[DW-1], dy[DW-1], dx[DW-1]};
      s1_mag[0] <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      s1_mag[1] <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      s1_mag[2] <= dz[DW-1] ? DW'(-dz) : DW'(dz);

      s2_deg <= s1_deg;
      s2_neg <= s1_neg;
      s2_mag <= s1_mag;
      s2_pf  <= lkat_pkg::msb_pos(s1_mag[0] | s1_mag[1] | s1_mag[2]);
      s2_ph  <= lkat_pkg::msb_pos(s1_mag[0] | s1_mag[2]);

      s3_side.degen <= s2_deg;
      s3_side.fneg  <= s2_neg;
      for (int i = 0; i < 3; i++) begin
        s3_side.fmag[i] <= lkat_pkg::scale_mag(s2_mag[i], s2_pf);
      end
      s3_side.hmag[0] <= lkat_pkg::scale_mag(s2_mag[0], s2_ph);
      s3_side.hmag[1] <= lkat_pkg::scale_mag(s2_mag[2], s2_ph);

      s4_side <= s3_side;
      for (int i = 0; i < 3; i++) begin
        s4_fsq[i] <= (2*MW)'(s3_side.fmag[i]) * (2*MW)'(s3_side.fmag[i]);
      end
      for (int i = 0; i < 2; i++) begin
        s4_hsq[i] <= (2*MW)'(s3_side.hmag[i]) * (2*MW)'(s3_side.hmag[i]);
      end

      s5_side <= s4_side;
      s5_fsum <= lkat_pkg::RAD_W'(s4_fsq[0]) + lkat_pkg::RAD_W'(s4_fsq[1])
               + lkat_pkg::RAD_W'(s4_fsq[2]);
      s5_hsum <= lkat_pkg::RAD_W'(s4_hsq[0]) + lkat_pkg::RAD_W'(s4_hsq[1]);

      qside[0] <= s5_side;
      qf[0]    <= lkat_pkg::sqrt_step('0, s5_fsum[lkat_pkg::RAD_W-1 -: 2]);
      qh[0]    <= lkat_pkg::sqrt_step('0, s5_hsum[lkat_pkg::RAD_W-1 -: 2]);
      qfr[0]   <= s5_fsum << 2;
      qhr[0]   <= s5_hsum << 2;
      for (int k = 1; k < NS; k++) begin
        qside[k] <= qside[k-1];
        qf[k]    <= lkat_pkg::sqrt_step(qf[k-1], qfr[k-1][lkat_pkg::RAD_W-1 -: 2]);
        qh[k]    <= lkat_pkg::sqrt_step(qh[k-1], qhr[k-1][lkat_pkg::RAD_W-1 -: 2]);
        qfr[k]   <= qfr[k-1] << 2;
        qhr[k]   <= qhr[k-1] << 2;
      end

      // rx takes +z, rz takes -x
      ddeg[0]    <= qside[NS-1].degen;
      dneg[0]    <= {!qside[NS-1].fneg[0], qside[NS-1].fneg[2], qside[NS-1].fneg};
      dl[0]      <= qf[NS-1].root;
      dh[0]      <= qh[NS-1].root;
      for (int i = 0; i < 3; i++) begin
        dacc[0][i] <= div_init(qside[NS-1].fmag[i], qf[NS-1].root);
      end
      dacc[0][3] <= div_init(qside[NS-1].hmag[1], qh[NS-1].root);
      dacc[0][4] <= div_init(qside[NS-1].hmag[0], qh[NS-1].root);
      for (int k = 1; k <= QB; k++) begin
        ddeg[k] <= ddeg[k-1];
        dneg[k] <= dneg[k-1];
        dl[k]   <= dl[k-1];
        dh[k]   <= dh[k-1];
        for (int i = 0; i < 5; i++) begin
          dacc[k][i] <= div_step(dacc[k-1][i], (i < 3) ? dl[k-1] : dh[k-1]);
        end
      end

      c_deg <= ddeg[QB];
      for (int i = 0; i < 5; i++) begin
        c_val[i] <= to_unit(dacc[QB][i][QB-1:0], dneg[QB][i]);
      end

      p_deg <= c_deg;
      p_val <= c_val;
      p1    <= PW'(c_val[1]) * PW'(c_val[4]);  // fy * rz
      p2    <= PW'(c_val[2]) * PW'(c_val[3]);  // fz * rx
      p3    <= PW'(c_val[0]) * PW'(c_val[4]);  // fx * rz
      p4    <= PW'(c_val[1]) * PW'(c_val[3]);  // fy * rx

      s_deg <= p_deg;
      s_val <= p_val;
      s_e1  <= SW'(p1);
      s_e4  <= SW'(p2) - SW'(p3);
      s_e7  <= -SW'(p4);

      degenerate    <= s_deg;
      m_right_y     <= '0;
      m_neg_right_x <= s_deg ? '0 : neg_out(s_val[3]);
      m_up_x        <= s_deg ? '0 : round_out(s_e1);
      m_neg_fwd_x   <= s_deg ? '0 : neg_out(s_val[0]);
      m_up_y        <= s_deg ? '0 : round_out(s_e4);
      m_neg_fwd_y   <= s_deg ? '0 : neg_out(s_val[1]);
      m_neg_right_z <= s_deg ? '0 : neg_out(s_val[4]);
      m_up_z        <= s_deg ? '0 : round_out(s_e7);
      m_neg_fwd_z   <= s_deg ? '0 : neg_out(s_val[2]);
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic signed [15:0] nrx, ux, nfx, ry, uy, nfy, nrz, uz, nfz;
    logic               dg;
  } mat_t;

  typedef struct {
    logic [31:0] ex, ey, ez, ax, ay, az;
    bit          known;
    mat_t        m;
  } vec_row_t;

  localparam int FRAC = 14;
  localparam longint QONE = 64'sd1 <<< FRAC;
  localparam int LAT = FRAC + 42;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] aim_x = '0, aim_y = '0, aim_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] m_neg_right_x, m_up_x, m_neg_fwd_x, m_right_y, m_up_y;
  logic signed [15:0] m_neg_fwd_y, m_neg_right_z, m_up_z, m_neg_fwd_z;
  logic degenerate;

  mat_t expected_mats[$];
  int   mismatches = 0;
  bit   rx_quiet = 1'b0;     // when set, the receiver makes no random stalls
  bit   tx_quiet = 1'b0;
  int   hold_off = 0;        // forced receiver stall, in cycles

  always #6 clk = ~clk;

  look_at_rotation_matrix dut (.*);

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Scale so the largest magnitude lands in [2^29, 2^30); shifts truncate magnitude.
  function automatic void norm_scale(ref longint c[3], input int n);
    longint unsigned m[3];
    longint unsigned top;
    top = 0;
    for (int i = 0; i < n; i++) begin
      m[i] = mag(c[i]);
      if (m[i] > top) top = m[i];
    end
    while (top >= (64'd1 << 30)) begin
      for (int i = 0; i < n; i++) m[i] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int i = 0; i < n; i++) m[i] <<= 1;
      top <<= 1;
    end
    for (int i = 0; i < n; i++) c[i] = c[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > QONE) return QONE;
    if (v < -QONE) return -QONE;
    return v;
  endfunction

  function automatic longint unit_quot(longint num, longint unsigned len);
    longint unsigned q;
    q = ((mag(num) << FRAC) + len / 2) / len;
    return clip_unit(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint round_frac(longint v);
    longint unsigned q;
    q = (mag(v) + (64'd1 << (FRAC - 1))) >> FRAC;
    return clip_unit(v < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic mat_t look_at(logic signed [31:0] ex, ey, ez, ax, ay, az);
    mat_t r;
    longint dx, dy, dz, fx, fy, fz, rx, rz;
    longint f[3], h[3];
    longint unsigned len, hl;
    r = '0;
    dx = longint'(ax) - longint'(ex);
    dy = longint'(ay) - longint'(ey);
    dz = longint'(az) - longint'(ez);
    if (dx == 0 && dz == 0) begin
      r.dg = 1'b1;
      return r;
    end
    f = '{dx, dy, dz};
    norm_scale(f, 3);
    len = int_sqrt(f[0] * f[0] + f[1] * f[1] + f[2] * f[2]);
    fx = unit_quot(f[0], len);
    fy = unit_quot(f[1], len);
    fz = unit_quot(f[2], len);
    h = '{dx, dz, 0};
    norm_scale(h, 2);
    hl = int_sqrt(h[0] * h[0] + h[1] * h[1]);
    rx = unit_quot(h[1], hl);
    rz = unit_quot(-h[0], hl);
    r.nrx = 16'(-rx);
    r.ux  = 16'(round_frac(fy * rz));
    r.nfx = 16'(-fx);
    r.ry  = '0;
    r.uy  = 16'(round_frac(fz * rx - fx * rz));
    r.nfy = 16'(-fy);
    r.nrz = 16'(-rz);
    r.uz  = 16'(round_frac(-(fy * rx)));
    r.nfz = 16'(-fz);
    return r;
  endfunction

  task automatic send(logic [31:0] ex, ey, ez, ax, ay, az, bit known, mat_t m);
    while (!tx_quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    aim_x <= ax; aim_y <= ay; aim_z <= az;
    expected_mats.push_back(known ? m : look_at(ex, ey, ez, ax, ay, az));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 8;
    endcase
  endfunction

  // Receiver: random stalls, forced hold-off, quiet stretch.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= !rx_quiet && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      mat_t got, exp_m;
      got = '{m_neg_right_x, m_up_x, m_neg_fwd_x, m_right_y, m_up_y,
              m_neg_fwd_y, m_neg_right_z, m_up_z, m_neg_fwd_z, degenerate};
      if (expected_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_m = expected_mats.pop_front();
        if (got !== exp_m) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h got %h", exp_m, got);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  localparam logic [31:0] PMAX = 32'h7FFFFFFF;
  localparam logic [31:0] NMAX = 32'h80000000;
  localparam logic [31:0] ONE  = 32'h00010000;

  initial begin
    vec_row_t rows[$];
    mat_t degen_m, fwd_z_m;
    degen_m = '0;
    degen_m.dg = 1'b1;
    // looking down +z: right = (1,0,0), up = (0,1,0), forward = (0,0,1)
    fwd_z_m = '0;
    fwd_z_m.nrx = -16'sd16384;
    fwd_z_m.uy  = 16'sd16384;
    fwd_z_m.nfz = -16'sd16384;
    rows = '{
      '{0, 0, 0, 0, 0, 0, 1, degen_m},
      '{0, 0, 0, 0, ONE, 0, 1, degen_m},
      '{5, NMAX, 7, 5, PMAX, 7, 1, degen_m},
      '{0, 0, 0, 0, 0, ONE, 1, fwd_z_m},
      '{0, 0, NMAX, 0, 0, PMAX, 1, fwd_z_m},
      '{PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, 0, '0},
      '{NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, 0, '0},
      '{NMAX, 0, 0, PMAX, 0, 0, 0, '0},
      '{PMAX, 0, 0, NMAX, 0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 32'hFFFF0000, 0, '0},
      '{0, 0, 0, 1, 0, 0, 0, '0},
      '{0, 0, 0, 0, 0, 1, 0, '0},
      '{0, 0, 0, 1, PMAX, 0, 0, '0},
      '{0, NMAX, 0, 0, PMAX, 1, 0, '0},
      '{0, 0, 0, ONE, ONE, ONE, 0, '0},
      '{0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0},
      '{0, 0, 0, 3, 0, 4, 0, '0},
      '{0, 0, 0, 1, 0, 1, 0, '0},
      '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
        32'hAAAAAAAA, 0, '0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send(rows[i].ex, rows[i].ey, rows[i].ez, rows[i].ax, rows[i].ay, rows[i].az,
           rows[i].known, rows[i].m);
    for (int n = 0; n < 750; n++) begin
      logic [31:0] ex, ey, ez, ax, ay, az;
      if (n == 150) hold_off <= 200;       // pipeline fills, input stalls
      if (n == 300) begin
        in_valid <= 1'b0;
        while (expected_mats.size() != 0) @(posedge clk);
      end
      tx_quiet = (n >= 400 && n < 500);
      rx_quiet = tx_quiet;
      ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
      ax = rand_coord(); ay = rand_coord(); az = rand_coord();
      if ($urandom_range(19) == 0) begin
        ax = ex;
        az = ez;
      end
      send(ex, ey, ez, ax, ay, az, 0, '0);
    end
    in_valid <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (mismatches == 0 && expected_mats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
